### rtl/core/md5_pkg.sv
// ----------------------------------------------------------------------------
// md5_pkg
// Shared types, constants and round tables of the md5 digest core.
// ----------------------------------------------------------------------------
package md5_pkg;

  typedef logic [3:0][31:0] md5_words_t;

  localparam md5_words_t CHAIN_INIT = {32'h10325476, 32'h98badcfe,
                                       32'hefcdab89, 32'h67452301};

  localparam logic [6:0] FULL_BLOCK = 7'd64;
  localparam logic [5:0] LAST_ROUND = 6'd63;
  localparam logic [5:0] LEN_POS    = 6'd56;
  localparam logic [7:0] PAD_MARK   = 8'h80;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_RUN,
    ST_ADD,
    ST_EMIT_LO,
    ST_EMIT_HI
  } md5_state_t;

  typedef enum logic [1:0] {
    MODE_NORMAL,
    MODE_MARK_LEN,
    MODE_MARK,
    MODE_LEN
  } md5_mode_t;

  typedef struct packed {
    logic       wr_en;
    logic [5:0] wr_pos;
    logic [7:0] wr_byte;
    logic [3:0] rd_idx;
    logic [6:0] keep;
    logic       mark;
    logic       len_en;
  } md5_buf_ctrl_t;

  typedef struct packed {
    logic       load;
    logic       step;
    logic [5:0] round;
    logic [5:0] rd_round;
  } md5_round_ctrl_t;

  function automatic logic [3:0] md5_msg_index(input logic [5:0] r);
    logic [3:0] m;
    logic [3:0] g;
    m = r[3:0];
    case (r[5:4])
      2'd0:    g = m;
      2'd1:    g = 4'((m << 2) + m + 4'd1);
      2'd2:    g = 4'((m << 1) + m + 4'd5);
      2'd3:    g = 4'((m << 3) - m);
      default: g = m;
    endcase
    return g;
  endfunction

  function automatic logic [4:0] md5_rot(input logic [5:0] r);
    logic [4:0] s;
    case ({r[5:4], r[1:0]})
      4'd0:    s = 5'd7;
      4'd1:    s = 5'd12;
      4'd2:    s = 5'd17;
      4'd3:    s = 5'd22;
      4'd4:    s = 5'd5;
      4'd5:    s = 5'd9;
      4'd6:    s = 5'd14;
      4'd7:    s = 5'd20;
      4'd8:    s = 5'd4;
      4'd9:    s = 5'd11;
      4'd10:   s = 5'd16;
      4'd11:   s = 5'd23;
      4'd12:   s = 5'd6;
      4'd13:   s = 5'd10;
      4'd14:   s = 5'd15;
      4'd15:   s = 5'd21;
      default: s = 5'd7;
    endcase
    return s;
  endfunction

  function automatic logic [31:0] md5_k(input logic [5:0] r);
    logic [31:0] k;
    case (r)
      6'd0:    k = 32'hd76aa478;
      6'd1:    k = 32'he8c7b756;
      6'd2:    k = 32'h242070db;
      6'd3:    k = 32'hc1bdceee;
      6'd4:    k = 32'hf57c0faf;
      6'd5:    k = 32'h4787c62a;
      6'd6:    k = 32'ha8304613;
      6'd7:    k = 32'hfd469501;
      6'd8:    k = 32'h698098d8;
      6'd9:    k = 32'h8b44f7af;
      6'd10:   k = 32'hffff5bb1;
      6'd11:   k = 32'h895cd7be;
      6'd12:   k = 32'h6b901122;
      6'd13:   k = 32'hfd987193;
      6'd14:   k = 32'ha679438e;
      6'd15:   k = 32'h49b40821;
      6'd16:   k = 32'hf61e2562;
      6'd17:   k = 32'hc040b340;
      6'd18:   k = 32'h265e5a51;
      6'd19:   k = 32'he9b6c7aa;
      6'd20:   k = 32'hd62f105d;
      6'd21:   k = 32'h02441453;
      6'd22:   k = 32'hd8a1e681;
      6'd23:   k = 32'he7d3fbc8;
      6'd24:   k = 32'h21e1cde6;
      6'd25:   k = 32'hc33707d6;
      6'd26:   k = 32'hf4d50d87;
      6'd27:   k = 32'h455a14ed;
      6'd28:   k = 32'ha9e3e905;
      6'd29:   k = 32'hfcefa3f8;
      6'd30:   k = 32'h676f02d9;
      6'd31:   k = 32'h8d2a4c8a;
      6'd32:   k = 32'hfffa3942;
      6'd33:   k = 32'h8771f681;
      6'd34:   k = 32'h6d9d6122;
      6'd35:   k = 32'hfde5380c;
      6'd36:   k = 32'ha4beea44;
      6'd37:   k = 32'h4bdecfa9;
      6'd38:   k = 32'hf6bb4b60;
      6'd39:   k = 32'hbebfbc70;
      6'd40:   k = 32'h289b7ec6;
      6'd41:   k = 32'heaa127fa;
      6'd42:   k = 32'hd4ef3085;
      6'd43:   k = 32'h04881d05;
      6'd44:   k = 32'hd9d4d039;
      6'd45:   k = 32'he6db99e5;
      6'd46:   k = 32'h1fa27cf8;
      6'd47:   k = 32'hc4ac5665;
      6'd48:   k = 32'hf4292244;
      6'd49:   k = 32'h432aff97;
      6'd50:   k = 32'hab9423a7;
      6'd51:   k = 32'hfc93a039;
      6'd52:   k = 32'h655b59c3;
      6'd53:   k = 32'h8f0ccc92;
      6'd54:   k = 32'hffeff47d;
      6'd55:   k = 32'h85845dd1;
      6'd56:   k = 32'h6fa87e4f;
      6'd57:   k = 32'hfe2ce6e0;
      6'd58:   k = 32'ha3014314;
      6'd59:   k = 32'h4e0811a1;
      6'd60:   k = 32'hf7537e82;
      6'd61:   k = 32'hbd3af235;
      6'd62:   k = 32'h2ad7d2bb;
      6'd63:   k = 32'heb86d391;
      default: k = 32'hd76aa478;
    endcase
    return k;
  endfunction

endpackage

### rtl/core/md5_in_if.sv
// ----------------------------------------------------------------------------
// md5_in_if
// Byte channel into the md5 core: one optional message byte and end mark.
// ----------------------------------------------------------------------------
interface md5_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       last_of_message;

  modport source (output valid, data_byte, byte_valid, last_of_message, input ready);
  modport sink   (input valid, data_byte, byte_valid, last_of_message, output ready);
endinterface

### rtl/core/md5_out_if.sv
// ----------------------------------------------------------------------------
// md5_out_if
// Digest channel out of the md5 core: one 64-bit half of the digest per word.
// ----------------------------------------------------------------------------
interface md5_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest_part;
  logic        is_last;

  modport source (output valid, digest_part, is_last, input ready);
  modport sink   (input valid, digest_part, is_last, output ready);
endinterface

### rtl/core/md5_block_buf.sv
// ----------------------------------------------------------------------------
// md5_block_buf
// 16 x 32-bit message block store with byte-lane writes and a padded read
// view: kept bytes, then the 0x80 mark, zeros and the bit length.
// ----------------------------------------------------------------------------
module md5_block_buf import md5_pkg::*; (
  input  logic          clk,
  input  md5_buf_ctrl_t ctrl,
  input  logic [63:0]   bit_len,
  output logic [31:0]   word
);

  logic [31:0] words [16];
  logic [31:0] raw;

  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      words[ctrl.wr_pos[5:2]][{ctrl.wr_pos[1:0], 3'b000} +: 8] <= ctrl.wr_byte;
    end
  end

  assign raw = words[ctrl.rd_idx];

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      logic [6:0] idx;
      idx = {1'b0, ctrl.rd_idx, 2'(j)};
      if (idx < ctrl.keep) begin
        word[8*j +: 8] = raw[8*j +: 8];
      end else if (ctrl.mark && idx == ctrl.keep) begin
        word[8*j +: 8] = PAD_MARK;
      end else if (ctrl.len_en && idx[5:0] >= LEN_POS) begin
        word[8*j +: 8] = bit_len[{idx[2:0], 3'b000} +: 8];
      end else begin
        word[8*j +: 8] = 8'h00;
      end
    end
  end

endmodule

### rtl/core/md5_round_unit.sv
// ----------------------------------------------------------------------------
// md5_round_unit
// Shared md5 round: working registers a..d, one round per step, with the
// next round's constant plus message word registered a round ahead.
// ----------------------------------------------------------------------------
module md5_round_unit import md5_pkg::*; (
  input  logic            clk,
  input  md5_round_ctrl_t ctrl,
  input  md5_words_t      chain,
  input  logic [31:0]     word,
  output md5_words_t      work
);

  logic [31:0] kw;
  logic [31:0] a, b, c, d;
  logic [31:0] f;
  logic [31:0] t;
  logic [63:0] rot_wide;
  logic [31:0] b_next;

  assign a = work[0];
  assign b = work[1];
  assign c = work[2];
  assign d = work[3];

  always_comb begin
    case (ctrl.round[5:4])
      2'd0:    f = d ^ (b & (c ^ d));
      2'd1:    f = c ^ (d & (b ^ c));
      2'd2:    f = b ^ c ^ d;
      2'd3:    f = c ^ (b | ~d);
      default: f = b ^ c ^ d;
    endcase
    t        = a + f + kw;
    rot_wide = {t, t} << md5_rot(ctrl.round);
    b_next   = b + rot_wide[63:32];
  end

  always_ff @(posedge clk) begin
    if (ctrl.load || ctrl.step) begin
      kw <= md5_k(ctrl.rd_round) + word;
    end
    if (ctrl.load) begin
      work <= chain;
    end else if (ctrl.step) begin
      work <= {c, b, b_next, d};
    end
  end

endmodule

### rtl/core/md5_message_digest_core.sv
// ----------------------------------------------------------------------------
// md5_message_digest_core
// MD5 digest over a byte stream with a shared round unit and a small sequencer.
// ----------------------------------------------------------------------------
// in_ch carries one word per message byte (byte_valid) and an optional end
// mark (last_of_message); a word with neither is taken and ignored.
// out_ch returns the 16-byte digest as two words, bytes 0..7 first
// (is_last 0), then bytes 8..15 (is_last 1).
// A byte word that does not complete a block leaves the core ready for the
// next word. The 64th byte of a block starts a compression: one load, 64
// rounds on the shared round unit, one chaining add. An end mark adds one
// padded compression, or two when 56 or more bytes sit in the open block,
// then the two digest words are offered. The round unit does one round per
// cycle.
// in_ch.ready is low while a compression runs and while the digest words
// wait; a stalled receiver holds the core with the digest stable. After the
// second digest word the core is back at its initial chaining value.
// rst is synchronous: the sequencer, byte count and chaining words return to
// their initial values.
// ----------------------------------------------------------------------------
module md5_message_digest_core import md5_pkg::*; (
  input  logic clk,
  input  logic rst,
  md5_in_if.sink    in_ch,
  md5_out_if.source out_ch
);

  md5_state_t      state, state_next;
  md5_mode_t       mode, mode_next;
  logic            finish, finish_next;
  logic [5:0]      round, round_next;
  logic [60:0]     count, count_next;
  md5_words_t      chain, chain_next;
  logic [127:0]    digest, digest_next;
  md5_words_t      work;
  md5_words_t      sum;
  logic [31:0]     word;
  md5_buf_ctrl_t   buf_ctrl;
  md5_round_ctrl_t rnd_ctrl;
  logic            in_fire;
  logic [60:0]     count_inc;
  logic [5:0]      pos_after;

  md5_block_buf u_buf (
    .clk     (clk),
    .ctrl    (buf_ctrl),
    .bit_len ({count, 3'b000}),
    .word    (word)
  );

  md5_round_unit u_round (
    .clk   (clk),
    .ctrl  (rnd_ctrl),
    .chain (chain),
    .word  (word),
    .work  (work)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      mode   <= MODE_NORMAL;
      finish <= 1'b0;
      round  <= '0;
      count  <= '0;
      chain  <= CHAIN_INIT;
    end else begin
      state  <= state_next;
      mode   <= mode_next;
      finish <= finish_next;
      round  <= round_next;
      count  <= count_next;
      chain  <= chain_next;
    end
    digest <= digest_next;
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      sum[i] = chain[i] + work[i];
    end
  end

  assign in_fire   = in_ch.valid && in_ch.ready;
  assign count_inc = count + 61'd1;
  assign pos_after = in_ch.byte_valid ? count_inc[5:0] : count[5:0];

  always_comb begin
    state_next  = state;
    mode_next   = mode;
    finish_next = finish;
    round_next  = round;
    count_next  = count;
    chain_next  = chain;
    digest_next = digest;

    in_ch.ready        = (state == ST_IDLE);
    out_ch.valid       = (state == ST_EMIT_LO) || (state == ST_EMIT_HI);
    out_ch.is_last     = (state == ST_EMIT_HI);
    out_ch.digest_part = (state == ST_EMIT_HI) ? digest[127:64] : digest[63:0];

    buf_ctrl.wr_en   = in_fire && in_ch.byte_valid;
    buf_ctrl.wr_pos  = count[5:0];
    buf_ctrl.wr_byte = in_ch.data_byte;
    buf_ctrl.mark    = (mode == MODE_MARK_LEN) || (mode == MODE_MARK);
    buf_ctrl.len_en  = (mode == MODE_MARK_LEN) || (mode == MODE_LEN);
    case (mode)
      MODE_NORMAL: buf_ctrl.keep = FULL_BLOCK;
      MODE_LEN:    buf_ctrl.keep = '0;
      default:     buf_ctrl.keep = {1'b0, count[5:0]};
    endcase

    rnd_ctrl.load     = (state == ST_LOAD);
    rnd_ctrl.step     = (state == ST_RUN);
    rnd_ctrl.round    = round;
    rnd_ctrl.rd_round = (state == ST_LOAD) ? 6'd0 : round + 6'd1;
    buf_ctrl.rd_idx   = md5_msg_index(rnd_ctrl.rd_round);

    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_ch.byte_valid) begin
            count_next = count_inc;
          end
          if (in_ch.byte_valid && count[5:0] == LAST_ROUND) begin
            mode_next   = MODE_NORMAL;
            finish_next = in_ch.last_of_message;
            state_next  = ST_LOAD;
          end else if (in_ch.last_of_message) begin
            mode_next   = (pos_after >= LEN_POS) ? MODE_MARK : MODE_MARK_LEN;
            finish_next = 1'b0;
            state_next  = ST_LOAD;
          end
        end
      end
      ST_LOAD: begin
        round_next = '0;
        state_next = ST_RUN;
      end
      ST_RUN: begin
        round_next = round + 6'd1;
        if (round == LAST_ROUND) begin
          state_next = ST_ADD;
        end
      end
      ST_ADD: begin
        chain_next = sum;
        case (mode)
          MODE_NORMAL: begin
            if (finish) begin
              mode_next   = MODE_MARK_LEN;
              finish_next = 1'b0;
              state_next  = ST_LOAD;
            end else begin
              state_next = ST_IDLE;
            end
          end
          MODE_MARK: begin
            mode_next  = MODE_LEN;
            state_next = ST_LOAD;
          end
          default: begin
            digest_next = sum;
            chain_next  = CHAIN_INIT;
            count_next  = '0;
            mode_next   = MODE_NORMAL;
            state_next  = ST_EMIT_LO;
          end
        endcase
      end
      ST_EMIT_LO: begin
        if (out_ch.ready) begin
          state_next = ST_EMIT_HI;
        end
      end
      ST_EMIT_HI: begin
        if (out_ch.ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ch.ready && out_ch.valid))
    else $error("input accepted while digest pending");

  a_round_end: assert property (@(posedge clk) disable iff (rst)
    state == ST_RUN && round == LAST_ROUND |=> state == ST_ADD)
    else $error("compression did not end after last round");

  a_digest_order: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.ready && !out_ch.is_last |=> out_ch.valid && out_ch.is_last)
    else $error("second digest word missing");

  a_reinit: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.is_last |-> count == '0 && chain == CHAIN_INIT)
    else $error("state not reinitialized with digest");
`endif

endmodule
